### hdl/rect_circle_fill_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle/circle fill rasterizer
// ----------------------------------------------------------------------------
`ifndef RECT_CIRCLE_FILL_RASTERIZER_ASSERT_SVH
`define RECT_CIRCLE_FILL_RASTERIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rcf_pkg.sv
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared constants, types and helpers of the rectangle/circle fill rasterizer.
// ----------------------------------------------------------------------------
package rcf_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Coordinates after classification are non-negative and below 2*128
  localparam int CRD_W  = 9;
  localparam int R2_W   = 2 * CRD_W;
  localparam int REG_W  = 7;
  localparam int COLOR_W = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [REG_W-1:0] SIZE_RESET = REG_W'(64);

  typedef enum logic [1:0] {
    MODE_RECT   = 2'd0,
    MODE_CIRCLE = 2'd1,
    MODE_FILL   = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_REJECT = 2'd0,
    KIND_PAINT  = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  // Classified command as held in the queue
  typedef struct packed {
    kind_t              kind;
    logic               circle;
    logic [CRD_W-1:0]   x0;
    logic [CRD_W-1:0]   x1;
    logic [CRD_W-1:0]   y0;
    logic [CRD_W-1:0]   y1;
    logic [CRD_W-1:0]   cx;
    logic [CRD_W-1:0]   cy;
    logic [CRD_W-1:0]   w;
    logic [R2_W-1:0]    r2;
    logic [ADDR_W-1:0]  base;   // first row address for paint, pixel address for read
    logic [COLOR_W-1:0] color;
  } cmd_t;

  // Saturate a size register into 1..max
  function automatic logic [CRD_W-1:0] eff_size(input logic [REG_W-1:0] v,
                                                input logic [CRD_W-1:0] max);
    logic [CRD_W-1:0] ext;
    ext = CRD_W'(v);
    if (ext == '0) return CRD_W'(1);
    if (ext > max) return max;
    return ext;
  endfunction

endpackage

### hdl/rcf_front.sv
// ----------------------------------------------------------------------------
// rcf_front
// Accepts drawing commands, runs the bounds check and turns each mode into a
// box walk or a pixel read for the back end.
// ----------------------------------------------------------------------------
module rcf_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic signed [7:0]             start_x,
  input  logic signed [7:0]             start_y,
  input  logic signed [7:0]             end_x,
  input  logic signed [7:0]             end_y,
  input  logic [rcf_pkg::COLOR_W-1:0]   paint_color,
  input  logic [rcf_pkg::CRD_W-1:0]     eff_w,
  input  logic [rcf_pkg::CRD_W-1:0]     eff_h,
  input  logic                          q_full,
  input  logic                          clearing,
  output logic                          push,
  output rcf_pkg::cmd_t                 cmd
);

  logic                        any_neg;
  logic                        read_neg;
  logic [rcf_pkg::CRD_W-1:0]   sx, sy, ex, ey;
  logic [rcf_pkg::CRD_W-1:0]   x_lo, x_hi, y_lo, y_hi;
  logic [rcf_pkg::CRD_W-1:0]   side, rad, y_end;
  logic                        box_bad;
  logic                        read_bad;
  logic [rcf_pkg::R2_W-1:0]    rad_sq;
  logic [rcf_pkg::R2_W-1:0]    row_prod;
  logic [rcf_pkg::R2_W-1:0]    rd_prod;
  rcf_pkg::mode_t              md;

  assign md = rcf_pkg::mode_t'(mode);

  assign in_ready = !q_full && !clearing;
  assign push     = in_valid && in_ready;

  assign sx = rcf_pkg::CRD_W'(start_x[6:0]);
  assign sy = rcf_pkg::CRD_W'(start_y[6:0]);
  assign ex = rcf_pkg::CRD_W'(end_x[6:0]);
  assign ey = rcf_pkg::CRD_W'(end_y[6:0]);

  assign any_neg  = start_x[7] || start_y[7] || end_x[7] || end_y[7];
  assign read_neg = start_x[7] || start_y[7];
  assign box_bad  = any_neg || (sx >= eff_w) || (ex >= eff_w) ||
                    (sy >= eff_h) || (ey >= eff_h);
  assign read_bad = read_neg || (sx >= eff_w) || (sy >= eff_h);

  assign x_lo = (sx > ex) ? ex : sx;
  assign x_hi = (sx > ex) ? sx : ex;
  assign y_lo = (sy > ey) ? ey : sy;
  assign y_hi = (sy > ey) ? sy : ey;

  // Circle: square of side x_hi-x_lo, rows past the frame dropped
  assign side   = x_hi - x_lo;
  assign rad    = side >> 1;
  assign rad_sq = rad * rad;
  assign y_end  = ((y_lo + side) > eff_h) ? eff_h : (y_lo + side);

  assign row_prod = y_lo * eff_w;
  assign rd_prod  = sy * eff_w;

  always_comb begin
    cmd        = '0;
    cmd.color  = paint_color;
    cmd.w      = eff_w;
    cmd.cx     = x_lo + rad;
    cmd.cy     = y_lo + rad;
    cmd.r2     = rad_sq;
    case (md)
      rcf_pkg::MODE_RECT, rcf_pkg::MODE_CIRCLE: begin
        cmd.kind   = box_bad ? rcf_pkg::KIND_REJECT : rcf_pkg::KIND_PAINT;
        cmd.circle = (md == rcf_pkg::MODE_CIRCLE);
        cmd.x0     = x_lo;
        cmd.x1     = x_hi;
        cmd.y0     = y_lo;
        cmd.y1     = (md == rcf_pkg::MODE_CIRCLE) ? y_end : y_hi;
        cmd.base   = row_prod[rcf_pkg::ADDR_W-1:0];
      end
      rcf_pkg::MODE_FILL: begin
        cmd.kind = rcf_pkg::KIND_PAINT;
        cmd.x1   = eff_w;
        cmd.y1   = eff_h;
      end
      default: begin
        cmd.kind = read_bad ? rcf_pkg::KIND_REJECT : rcf_pkg::KIND_READ;
        cmd.base = rcf_pkg::ADDR_W'(rd_prod[rcf_pkg::ADDR_W-1:0] + rcf_pkg::ADDR_W'(sx));
      end
    endcase
  end

endmodule

### hdl/rcf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// rcf_cmd_fifo
// Short queue of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
module rcf_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rcf_pkg::cmd_t push_cmd,
  input  logic          pop,
  output rcf_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);

  rcf_pkg::cmd_t                slots [rcf_pkg::QUEUE_DEPTH];
  logic [rcf_pkg::QPTR_W-1:0]   wr_ptr;
  logic [rcf_pkg::QPTR_W-1:0]   rd_ptr;
  logic [rcf_pkg::QPTR_W:0]     count;

  assign empty = (count == '0);
  assign full  = (count == (rcf_pkg::QPTR_W+1)'(rcf_pkg::QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/rcf_back.sv
// ----------------------------------------------------------------------------
// rcf_back
// Drawing engine: owns the pixel store, clears it after reset, walks each
// command's box one pixel per cycle and returns one result per command.
// ----------------------------------------------------------------------------
`include "rect_circle_fill_rasterizer_assert.svh"

module rcf_back (
  input  logic                         clk,
  input  logic                         rst,
  input  rcf_pkg::cmd_t                head,
  input  logic                         q_empty,
  output logic                         pop,
  output logic                         clearing,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rcf_pkg::COLOR_W-1:0]  out_pixel,
  output logic                         out_rejected
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAINT,
    ST_READ,
    ST_DONE
  } state_t;

  state_t                         state;
  rcf_pkg::cmd_t                  cur;
  logic [rcf_pkg::CRD_W-1:0]      col;
  logic [rcf_pkg::CRD_W-1:0]      row;
  logic [rcf_pkg::ADDR_W-1:0]     row_base;
  logic [rcf_pkg::ADDR_W-1:0]     clr_addr;

  logic [rcf_pkg::COLOR_W-1:0]    frame_store [rcf_pkg::STORE_DEPTH];
  logic [rcf_pkg::COLOR_W-1:0]    rd_data;

  logic                           we;
  logic [rcf_pkg::ADDR_W-1:0]     waddr;
  logic [rcf_pkg::COLOR_W-1:0]    wdata;

  logic signed [rcf_pkg::CRD_W:0] dx, dy;
  logic [2*rcf_pkg::CRD_W+2:0]    dist_sq;
  logic                           in_circle;
  logic                           col_last, row_last;
  logic                           box_empty;

  assign clearing = (state == ST_CLEAR);
  assign pop      = (state == ST_IDLE) && !q_empty;

  assign dx        = $signed({1'b0, col}) - $signed({1'b0, cur.cx});
  assign dy        = $signed({1'b0, row}) - $signed({1'b0, cur.cy});
  assign dist_sq   = (2*rcf_pkg::CRD_W+3)'(unsigned'(dx * dx)) +
                     (2*rcf_pkg::CRD_W+3)'(unsigned'(dy * dy));
  assign in_circle = (dist_sq <= (2*rcf_pkg::CRD_W+3)'(cur.r2));

  assign col_last  = (col + 1'b1) == cur.x1;
  assign row_last  = (row + 1'b1) == cur.y1;
  assign box_empty = (head.x0 >= head.x1) || (head.y0 >= head.y1);

  always_comb begin
    we    = 1'b0;
    waddr = row_base + rcf_pkg::ADDR_W'(col);
    wdata = cur.color;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      ST_PAINT: we = !cur.circle || in_circle;
      default:  we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) frame_store[waddr] <= wdata;
    rd_data <= frame_store[cur.base];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
      out_pixel    <= '0;
      out_rejected <= 1'b0;
    end else begin
      // ST_DONE reloads the output register itself
      if (out_valid && out_ready && (state != ST_DONE)) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (pop) begin
            cur      <= head;
            col      <= head.x0;
            row      <= head.y0;
            row_base <= head.base;
            case (head.kind)
              rcf_pkg::KIND_PAINT: state <= box_empty ? ST_DONE : ST_PAINT;
              rcf_pkg::KIND_READ:  state <= ST_READ;
              default:             state <= ST_DONE;
            endcase
          end
        end
        ST_PAINT: begin
          if (col_last) begin
            col      <= cur.x0;
            row      <= row + 1'b1;
            row_base <= row_base + rcf_pkg::ADDR_W'(cur.w);
            if (row_last) state <= ST_DONE;
          end else begin
            col <= col + 1'b1;
          end
        end
        ST_READ: state <= ST_DONE;
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            out_pixel    <= (cur.kind == rcf_pkg::KIND_READ) ? rd_data : '0;
            out_rejected <= (cur.kind == rcf_pkg::KIND_REJECT);
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `RCF_ASSERT_NOW(a_paint_in_box, state == ST_PAINT, (col < cur.x1) && (row < cur.y1), "paint walk left its box")
  `RCF_ASSERT_NOW(a_no_pop_clear, state == ST_CLEAR, !pop, "command taken during store clear")
  `RCF_ASSERT_NEXT(a_read_done, state == ST_READ, state == ST_DONE, "read did not finish in one cycle")
  `RCF_ASSERT_NEXT(a_pop_leaves_idle, pop, state != ST_IDLE, "engine stayed idle after taking a command")

endmodule

### hdl/rect_circle_fill_rasterizer.sv
// ----------------------------------------------------------------------------
// rect_circle_fill_rasterizer
// Frame buffer with a rectangle, circle and whole-frame fill engine.
// ----------------------------------------------------------------------------
// Commands enter on the s_axis stream, one per transfer; every command gives
// exactly one result transfer on m_axis (pixel color for reads, zero
// otherwise, plus the rejected flag). frame_width and frame_height must be
// set through the APB port only while the block is idle; the block itself
// does not enforce this. After reset the 64x64 store is swept to zero, one
// pixel per cycle, and s_axis_tready stays low until the sweep ends; APB
// writes are taken meanwhile. A paint command walks every pixel of its
// bounding box (rows past the frame height excluded for circles); a whole
// fill walks the full frame. Reads and rejected commands skip the walk.
// The single write port of the store, walked one pixel per cycle by the
// engine, sets the rate.
// Classified commands wait in a four-entry queue, so the input keeps
// taking commands while the engine draws. A stalled m_axis holds the result
// in its output register; the engine then stops after its current command.
// ----------------------------------------------------------------------------
module rect_circle_fill_rasterizer (
  input  logic        clk,
  input  logic        rst,
  // s_axis_tdata: mode[1:0], start_x[9:2], start_y[17:10], end_x[25:18],
  //               end_y[33:26], paint_color[65:34], zero pad [71:66]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  // m_axis_tdata: pixel_value[31:0], rejected[32], zero pad [39:33]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [rcf_pkg::REG_W-1:0]   frame_width;
  logic [rcf_pkg::REG_W-1:0]   frame_height;
  logic [rcf_pkg::CRD_W-1:0]   eff_w;
  logic [rcf_pkg::CRD_W-1:0]   eff_h;
  logic                        cfg_wr;

  rcf_pkg::cmd_t               push_cmd;
  rcf_pkg::cmd_t               head;
  logic                        push, pop, q_empty, q_full, clearing;
  logic [rcf_pkg::COLOR_W-1:0] out_pixel;
  logic                        out_rejected;

  // register select: byte address 0 width, 4 height
  localparam logic SEL_WIDTH  = 1'b0;
  localparam logic SEL_HEIGHT = 1'b1;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rcf_pkg::SIZE_RESET;
      frame_height <= rcf_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == SEL_WIDTH)  frame_width  <= pwdata[rcf_pkg::REG_W-1:0];
      if (paddr[2] == SEL_HEIGHT) frame_height <= pwdata[rcf_pkg::REG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == SEL_HEIGHT) ? 32'(frame_height) : 32'(frame_width);

  assign eff_w = rcf_pkg::eff_size(frame_width,  rcf_pkg::CRD_W'(rcf_pkg::MAX_WIDTH));
  assign eff_h = rcf_pkg::eff_size(frame_height, rcf_pkg::CRD_W'(rcf_pkg::MAX_HEIGHT));

  rcf_front u_front (
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .mode        (s_axis_tdata[1:0]),
    .start_x     (s_axis_tdata[9:2]),
    .start_y     (s_axis_tdata[17:10]),
    .end_x       (s_axis_tdata[25:18]),
    .end_y       (s_axis_tdata[33:26]),
    .paint_color (s_axis_tdata[65:34]),
    .eff_w       (eff_w),
    .eff_h       (eff_h),
    .q_full      (q_full),
    .clearing    (clearing),
    .push        (push),
    .cmd         (push_cmd)
  );

  rcf_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  rcf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .clearing     (clearing),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_pixel    (out_pixel),
    .out_rejected (out_rejected)
  );

  assign m_axis_tdata = {7'b0, out_rejected, out_pixel};

endmodule
